### rtl/spg_pkg.sv
// Shared types, constants and lookup tables of the stimulation pulse generator.
package spg_pkg;

  // Timing and DAC set-up
  localparam int unsigned TICKS_PER_MS = 5;
  localparam int unsigned DAC_BITS     = 12;

  // Field widths
  localparam int unsigned LEVEL_W  = 12;
  localparam int unsigned WIDTH_W  = 5;
  localparam int unsigned PERIOD_W = 11;
  localparam int unsigned PHASE_W  = 14;
  localparam int unsigned COUNT_W  = 3;
  localparam int unsigned TPM_W    = $clog2(TICKS_PER_MS + 1);
  localparam int unsigned GAP_W    = PERIOD_W + TPM_W;

  localparam logic [PHASE_W-1:0] PHASE_MAX = {PHASE_W{1'b1}};
  localparam logic [LEVEL_W-1:0] AMP_MASK  = LEVEL_W'((1 << DAC_BITS) - 1);

  // Command characters
  localparam logic [7:0] CHAR_T      = 8'h54;
  localparam logic [7:0] CHAR_ONE    = 8'h31;
  localparam logic [7:0] CHAR_AMPMAX = 8'h35;
  localparam logic [7:0] CHAR_TIMMAX = 8'h34;

  // Byte count handling
  localparam logic [COUNT_W-1:0] CNT_FULL = 3'd3;
  localparam logic [COUNT_W-1:0] CNT_SAT  = 3'd4;

  // Reset settings
  localparam logic [LEVEL_W-1:0]  AMP_RST    = 12'd1200;
  localparam logic [WIDTH_W-1:0]  WIDTH_RST  = 5'd10;
  localparam logic [PERIOD_W-1:0] PERIOD_RST = 11'd1000;

  typedef enum logic {
    CMD_BYTE = 1'b0,
    CMD_TICK = 1'b1
  } cmd_e;

  typedef struct packed {
    logic [LEVEL_W-1:0]  amplitude;
    logic [WIDTH_W-1:0]  width;
    logic [PERIOD_W-1:0] period;
  } settings_t;

  typedef struct packed {
    logic accepted;
    logic rejected;
  } parse_status_t;

  typedef struct packed {
    logic               pulse_on;
    logic [LEVEL_W-1:0] level;
  } drive_t;

  function automatic logic [LEVEL_W-1:0] amp_lut(input logic [2:0] idx);
    logic [LEVEL_W-1:0] val;
    case (idx)
      3'd0:    val = 12'd400;
      3'd1:    val = 12'd800;
      3'd2:    val = 12'd1200;
      3'd3:    val = 12'd1600;
      3'd4:    val = 12'd2000;
      default: val = 12'd0;
    endcase
    return val;
  endfunction

  function automatic logic [WIDTH_W-1:0] width_lut(input logic [1:0] idx);
    logic [WIDTH_W-1:0] val;
    case (idx)
      2'd0:    val = 5'd5;
      2'd1:    val = 5'd10;
      2'd2:    val = 5'd15;
      default: val = 5'd20;
    endcase
    return val;
  endfunction

  function automatic logic [PERIOD_W-1:0] period_lut(input logic [1:0] idx);
    logic [PERIOD_W-1:0] val;
    case (idx)
      2'd0:    val = 11'd2000;
      2'd1:    val = 11'd1000;
      2'd2:    val = 11'd500;
      default: val = 11'd333;
    endcase
    return val;
  endfunction

endpackage

### rtl/spg_parser.sv
// Serial command parser: collects digits and loads pulse settings on 'T' if the three digits are valid.
module spg_parser (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   byte_en_i,
  input  logic [7:0]             rx_byte_i,
  output spg_pkg::settings_t     settings_o,
  output spg_pkg::parse_status_t status_o
);

  logic [7:0]                  chars_q [3];
  logic [spg_pkg::COUNT_W-1:0] count_q, count_d;
  spg_pkg::settings_t          set_q, set_d;
  logic                        is_t, cmd_ok;
  logic [7:0]                  off_amp, off_wid, off_per;

  assign is_t    = (rx_byte_i == spg_pkg::CHAR_T);
  assign off_amp = chars_q[0] - spg_pkg::CHAR_ONE;
  assign off_wid = chars_q[1] - spg_pkg::CHAR_ONE;
  assign off_per = chars_q[2] - spg_pkg::CHAR_ONE;

  assign cmd_ok = (count_q == spg_pkg::CNT_FULL)
                && (chars_q[0] >= spg_pkg::CHAR_ONE) && (chars_q[0] <= spg_pkg::CHAR_AMPMAX)
                && (chars_q[1] >= spg_pkg::CHAR_ONE) && (chars_q[1] <= spg_pkg::CHAR_TIMMAX)
                && (chars_q[2] >= spg_pkg::CHAR_ONE) && (chars_q[2] <= spg_pkg::CHAR_TIMMAX);

  always_comb begin
    count_d           = count_q;
    set_d             = set_q;
    status_o.accepted = 1'b0;
    status_o.rejected = 1'b0;
    if (byte_en_i) begin
      if (is_t) begin
        count_d = '0;
        if (cmd_ok) begin
          set_d.amplitude   = spg_pkg::amp_lut(off_amp[2:0]);
          set_d.width       = spg_pkg::width_lut(off_wid[1:0]);
          set_d.period      = spg_pkg::period_lut(off_per[1:0]);
          status_o.accepted = 1'b1;
        end else begin
          status_o.rejected = 1'b1;
        end
      end else if (count_q < spg_pkg::CNT_SAT) begin
        count_d = count_q + 3'd1;
      end
    end
  end

  // Store digits; drop anything past the third
  always_ff @(posedge clk_i) begin
    if (byte_en_i && !is_t && (count_q < spg_pkg::CNT_FULL)) begin
      chars_q[count_q[1:0]] <= rx_byte_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q         <= '0;
      set_q.amplitude <= spg_pkg::AMP_RST;
      set_q.width     <= spg_pkg::WIDTH_RST;
      set_q.period    <= spg_pkg::PERIOD_RST;
    end else begin
      count_q <= count_d;
      set_q   <= set_d;
    end
  end

  assign settings_o = set_q;

endmodule

### rtl/spg_timer.sv
// Pulse/gap phase timer driving the DAC level.
module spg_timer (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               tick_en_i,
  input  spg_pkg::settings_t settings_i,
  output spg_pkg::drive_t    drive_o
);

  logic                        in_pulse_q, in_pulse_d;
  logic [spg_pkg::PHASE_W-1:0] left_q, left_d, load;
  logic [spg_pkg::LEVEL_W-1:0] live_q, live_d;
  logic [spg_pkg::GAP_W-1:0]   gap_full;
  logic [spg_pkg::PHASE_W-1:0] gap_len;

  assign gap_full = spg_pkg::GAP_W'(settings_i.period)
                  * spg_pkg::GAP_W'(spg_pkg::TICKS_PER_MS);
  assign gap_len  = (gap_full > spg_pkg::GAP_W'(spg_pkg::PHASE_MAX))
                  ? spg_pkg::PHASE_MAX : gap_full[spg_pkg::PHASE_W-1:0];

  always_comb begin
    in_pulse_d = in_pulse_q;
    left_d     = left_q;
    live_d     = live_q;
    load       = left_q;
    if (tick_en_i) begin
      if (left_q == '0) begin
        if (in_pulse_q) begin
          live_d = settings_i.amplitude & spg_pkg::AMP_MASK;
          load   = spg_pkg::PHASE_W'(settings_i.width);
        end else begin
          load = gap_len;
        end
        if (load == '0) begin
          load = spg_pkg::PHASE_W'(1);
        end
      end
      left_d = load - spg_pkg::PHASE_W'(1);
      if (left_d == '0) begin
        in_pulse_d = !in_pulse_q;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_pulse_q <= 1'b1;
      left_q     <= '0;
      live_q     <= '0;
    end else begin
      in_pulse_q <= in_pulse_d;
      left_q     <= left_d;
      live_q     <= live_d;
    end
  end

  // Phase of the latest tick: a phase that just ended has already flipped
  always_comb begin
    drive_o.pulse_on = (left_d != '0) ? in_pulse_d : !in_pulse_d;
    drive_o.level    = drive_o.pulse_on ? live_d : '0;
  end

endmodule

### rtl/stim_pulse_generator_cmd.sv
// Top level of the stimulation pulse generator with serial command parser.
//
// Input channel (in_valid_i / in_stall_o): one item per handshake, either a
// received serial byte (command_i = 0, rx_byte_i) or one time tick
// (command_i = 1). Output channel (out_valid_o / out_stall_i): one result
// item per input item, in order: DAC level, pulse flag, and the accept and
// reject flags of a 'T' command.
// An item accepted into the input register is processed from there, and its
// result is written into the result register once the result slot is free.
// Throughput: one item per cycle; input register and result register form a
// two-stage pipeline that advances whenever the result slot is free.
// A stalled receiver holds the result register; the input register then
// holds its item and in_stall_o rises until the result is taken.
// Reset: empties both stages, clears the byte count, restores amplitude
// 1200, width 10 ticks, period 1000 ms, and starts in the pulse phase with
// the DAC at zero until the first tick.
module stim_pulse_generator_cmd (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        command_i,
  input  logic [7:0]  rx_byte_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [11:0] dac_level_o,
  output logic        pulse_on_o,
  output logic        settings_accepted_o,
  output logic        settings_rejected_o
);

  logic                        in_valid_q;
  logic                        cmd_q;
  logic [7:0]                  byte_q;
  logic                        out_valid_q;
  logic [spg_pkg::LEVEL_W-1:0] level_q;
  logic                        pulse_q, acc_q, rej_q;

  logic                  advance, step;
  logic                  byte_en, tick_en;
  spg_pkg::settings_t    settings;
  spg_pkg::parse_status_t status;
  spg_pkg::drive_t       drive;

  // Advance when the result slot is empty or being taken
  assign advance    = !out_valid_q || !out_stall_i;
  assign step       = in_valid_q && advance;
  assign in_stall_o = in_valid_q && !advance;

  assign byte_en = step && (cmd_q == spg_pkg::CMD_BYTE);
  assign tick_en = step && (cmd_q == spg_pkg::CMD_TICK);

  spg_parser u_parser (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .byte_en_i  (byte_en),
    .rx_byte_i  (byte_q),
    .settings_o (settings),
    .status_o   (status)
  );

  spg_timer u_timer (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .tick_en_i  (tick_en),
    .settings_i (settings),
    .drive_o    (drive)
  );

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      cmd_q  <= command_i;
      byte_q <= rx_byte_i;
    end
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      level_q <= drive.level;
      pulse_q <= drive.pulse_on;
      acc_q   <= status.accepted;
      rej_q   <= status.rejected;
    end
  end

  assign out_valid_o         = out_valid_q;
  assign dac_level_o         = level_q;
  assign pulse_on_o          = pulse_q;
  assign settings_accepted_o = acc_q;
  assign settings_rejected_o = rej_q;

endmodule

### tb/tb.sv
// Self-checking testbench for the stimulation pulse generator and its command parser.
module tb;

  // Give up after this many cycles in which neither channel moves an item.
  localparam int unsigned QUIET_LIMIT = 3000;
  localparam int unsigned SHOWN_MISMATCHES = 10;

  // Setting tables, lowest digit in the lowest slot.
  localparam logic [4:0][spg_pkg::LEVEL_W-1:0] AMP_CODES =
    {12'd2000, 12'd1600, 12'd1200, 12'd800, 12'd400};
  localparam logic [3:0][spg_pkg::WIDTH_W-1:0] WIDTH_CODES = {5'd20, 5'd15, 5'd10, 5'd5};
  localparam logic [3:0][spg_pkg::PERIOD_W-1:0] PERIOD_CODES =
    {11'd333, 11'd500, 11'd1000, 11'd2000};

  localparam logic [7:0] CHAR_ZERO = 8'h30;

  typedef struct packed {
    logic [spg_pkg::LEVEL_W-1:0] level;
    logic                        pulse_on;
    logic                        accepted;
    logic                        rejected;
  } drive_result_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic        command_i = spg_pkg::CMD_BYTE;
  logic [7:0]  rx_byte_i = 8'h00;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [11:0] dac_level_o;
  logic        pulse_on_o;
  logic        settings_accepted_o;
  logic        settings_rejected_o;

  stim_pulse_generator_cmd dut (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .in_valid_i          (in_valid_i),
    .in_stall_o          (in_stall_o),
    .command_i           (command_i),
    .rx_byte_i           (rx_byte_i),
    .out_valid_o         (out_valid_o),
    .out_stall_i         (out_stall_i),
    .dac_level_o         (dac_level_o),
    .pulse_on_o          (pulse_on_o),
    .settings_accepted_o (settings_accepted_o),
    .settings_rejected_o (settings_rejected_o)
  );

  always #10 clk_i = ~clk_i;

  // Idle rates in percent for each side; the phases of the run change them.
  int unsigned sender_idle_pct = 8;
  int unsigned receiver_idle_pct = 74;

  drive_result_t expected_drive_q[$];
  int unsigned   mismatches = 0;
  int unsigned   items_sent = 0;
  int unsigned   quiet_cycles = 0;

  // Predicted state of the stimulator: command store, settings and pulse timing.
  logic [7:0]                   cmd_store[3];
  logic [spg_pkg::COUNT_W-1:0]  stored_bytes = '0;
  logic [spg_pkg::LEVEL_W-1:0]  set_amp = 12'd1200;
  logic [spg_pkg::WIDTH_W-1:0]  set_width = 5'd10;
  logic [spg_pkg::PERIOD_W-1:0] set_period = 11'd1000;
  logic                         pulse_phase = 1'b1;
  logic [spg_pkg::PHASE_W-1:0]  ticks_left = '0;
  logic [spg_pkg::LEVEL_W-1:0]  drive_amp = '0;
  int unsigned                  commands_taken = 0;
  int unsigned                  commands_refused = 0;
  int unsigned                  pulse_starts = 0;

  function automatic logic digit_in_range(input logic [7:0] c, input logic [7:0] top);
    return (c >= spg_pkg::CHAR_ONE) && (c <= top);
  endfunction

  // Advance the predicted state by one item and queue the result it causes.
  task automatic advance_stimulator(input spg_pkg::cmd_e cmd, input logic [7:0] data);
    drive_result_t res;
    int unsigned   gap_len;
    logic          driving;
    res = '0;
    if (cmd == spg_pkg::CMD_TICK) begin
      // Load a new phase when the last one has run out.
      if (ticks_left == 0) begin
        if (pulse_phase) begin
          drive_amp  = set_amp & spg_pkg::AMP_MASK;
          ticks_left = spg_pkg::PHASE_W'(set_width);
          pulse_starts++;
        end else begin
          gap_len    = set_period * spg_pkg::TICKS_PER_MS;
          ticks_left = (gap_len > spg_pkg::PHASE_MAX) ? spg_pkg::PHASE_MAX
                                                      : spg_pkg::PHASE_W'(gap_len);
        end
        if (ticks_left == 0) ticks_left = spg_pkg::PHASE_W'(1);
      end
      ticks_left--;
      if (ticks_left == 0) pulse_phase = ~pulse_phase;
    end else if (data == spg_pkg::CHAR_T) begin
      if (stored_bytes == spg_pkg::CNT_FULL &&
          digit_in_range(cmd_store[0], spg_pkg::CHAR_AMPMAX) &&
          digit_in_range(cmd_store[1], spg_pkg::CHAR_TIMMAX) &&
          digit_in_range(cmd_store[2], spg_pkg::CHAR_TIMMAX)) begin
        set_amp    = AMP_CODES[cmd_store[0] - spg_pkg::CHAR_ONE];
        set_width  = WIDTH_CODES[cmd_store[1] - spg_pkg::CHAR_ONE];
        set_period = PERIOD_CODES[cmd_store[2] - spg_pkg::CHAR_ONE];
        res.accepted = 1'b1;
        commands_taken++;
      end else begin
        res.rejected = 1'b1;
        commands_refused++;
      end
      stored_bytes = '0;
    end else begin
      // Store up to three bytes; the count sticks at its saturated value.
      if (stored_bytes < spg_pkg::CNT_FULL) cmd_store[stored_bytes[1:0]] = data;
      if (stored_bytes < spg_pkg::CNT_SAT) stored_bytes++;
    end
    // A phase that just ended has already flipped, so look one step back.
    driving = (ticks_left != 0) ? pulse_phase : ~pulse_phase;
    if (driving) begin
      res.level    = drive_amp;
      res.pulse_on = 1'b1;
    end
    expected_drive_q.push_back(res);
  endtask

  // Offer one item, idling first at the sender's rate, and hold it until taken.
  task automatic send_item(input spg_pkg::cmd_e cmd, input logic [7:0] data);
    while ($urandom_range(0, 99) < sender_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    command_i  <= cmd;
    rx_byte_i  <= data;
    do begin
      @(posedge clk_i);
    end while (in_stall_o);
    advance_stimulator(cmd, data);
    items_sent++;
  endtask

  // The byte field carries noise on ticks, which the block must ignore.
  task automatic send_tick();
    send_item(spg_pkg::CMD_TICK, 8'($urandom_range(0, 255)));
  endtask

  task automatic send_command(input logic [7:0] amp, input logic [7:0] wid,
                              input logic [7:0] per);
    send_item(spg_pkg::CMD_BYTE, amp);
    send_item(spg_pkg::CMD_BYTE, wid);
    send_item(spg_pkg::CMD_BYTE, per);
    send_item(spg_pkg::CMD_BYTE, spg_pkg::CHAR_T);
  endtask

  // Bytes before the first tick read zero drive; a bare 'T' on a short store refuses.
  task automatic test_first_items();
    send_item(spg_pkg::CMD_BYTE, 8'h00);
    send_tick();
    send_tick();
    send_item(spg_pkg::CMD_BYTE, spg_pkg::CHAR_T);
  endtask

  // Lowest and highest valid digits in every position.
  task automatic test_command_extremes();
    send_command(spg_pkg::CHAR_ONE, spg_pkg::CHAR_ONE, spg_pkg::CHAR_ONE);
    send_tick();
    send_command(spg_pkg::CHAR_AMPMAX, spg_pkg::CHAR_TIMMAX, spg_pkg::CHAR_TIMMAX);
    send_tick();
  endtask

  // Digits just outside each range, and an over-long command that saturates the count.
  task automatic test_bad_commands();
    send_command(spg_pkg::CHAR_ONE, CHAR_ZERO, 8'(spg_pkg::CHAR_TIMMAX + 1));
    send_command(8'(spg_pkg::CHAR_AMPMAX + 1), spg_pkg::CHAR_ONE, spg_pkg::CHAR_ONE);
    send_item(spg_pkg::CMD_BYTE, spg_pkg::CHAR_ONE);
    send_item(spg_pkg::CMD_BYTE, spg_pkg::CHAR_ONE);
    send_item(spg_pkg::CMD_BYTE, spg_pkg::CHAR_ONE);
    send_item(spg_pkg::CMD_BYTE, spg_pkg::CHAR_ONE);
    send_item(spg_pkg::CMD_BYTE, 8'hFF);
    send_item(spg_pkg::CMD_BYTE, spg_pkg::CHAR_T);
  endtask

  // Run on ticks at the shortest gap until the next pulse starts, retuning
  // amplitude and width now and then so the next pulse start samples fresh values.
  task automatic test_pulse_train();
    int unsigned first_start;
    send_command(8'(spg_pkg::CHAR_ONE + $urandom_range(0, 4)),
                 8'(spg_pkg::CHAR_ONE + $urandom_range(0, 3)), spg_pkg::CHAR_TIMMAX);
    first_start = pulse_starts;
    while (pulse_starts < first_start + 1) begin
      if ($urandom_range(0, 149) == 0)
        send_command(8'(spg_pkg::CHAR_ONE + $urandom_range(0, 4)),
                     8'(spg_pkg::CHAR_ONE + $urandom_range(0, 3)), spg_pkg::CHAR_TIMMAX);
      else
        send_tick();
    end
  endtask

  // Mostly well-formed commands and tick bursts, with broken commands and noise.
  task automatic test_random_traffic(input int unsigned count);
    int unsigned stop_at;
    int unsigned pick;
    int unsigned n;
    stop_at = items_sent + count;
    while (items_sent < stop_at) begin
      pick = $urandom_range(0, 99);
      if (pick < 50) begin
        n = $urandom_range(1, 30);
        repeat (n) send_tick();
      end else if (pick < 80) begin
        if ($urandom_range(0, 99) < 85)
          send_command(8'(spg_pkg::CHAR_ONE + $urandom_range(0, 4)),
                       8'(spg_pkg::CHAR_ONE + $urandom_range(0, 3)),
                       8'(spg_pkg::CHAR_ONE + $urandom_range(0, 3)));
        else
          send_command(8'(CHAR_ZERO + $urandom_range(0, 9)), 8'(CHAR_ZERO + $urandom_range(0, 9)),
                       8'(CHAR_ZERO + $urandom_range(0, 9)));
      end else if (pick < 90) begin
        n = $urandom_range(0, 5);
        repeat (n) send_item(spg_pkg::CMD_BYTE, 8'($urandom_range(0, 255)));
        send_item(spg_pkg::CMD_BYTE, spg_pkg::CHAR_T);
      end else begin
        send_item(spg_pkg::CMD_BYTE, 8'($urandom_range(0, 255)));
      end
    end
  endtask

  // Take each result at the receiver, compare it with the oldest prediction,
  // then pick the stall for the next cycle.
  always @(posedge clk_i) begin
    drive_result_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_drive_q.size() == 0) begin
        mismatches++;
        if (mismatches <= SHOWN_MISMATCHES)
          $display("unexpected result: level %0d pulse %b accepted %b rejected %b",
                   dac_level_o, pulse_on_o, settings_accepted_o, settings_rejected_o);
      end else begin
        want = expected_drive_q.pop_front();
        if (dac_level_o !== want.level || pulse_on_o !== want.pulse_on ||
            settings_accepted_o !== want.accepted || settings_rejected_o !== want.rejected) begin
          mismatches++;
          if (mismatches <= SHOWN_MISMATCHES)
            $display("mismatch: level %0d/%0d pulse %b/%b accepted %b/%b rejected %b/%b %s",
                     want.level, dac_level_o, want.pulse_on, pulse_on_o,
                     want.accepted, settings_accepted_o, want.rejected,
                     settings_rejected_o, "(expected/actual)");
        end
      end
    end
    out_stall_i <= ($urandom_range(0, 99) < receiver_idle_pct);
  end

  // Watchdog: count cycles in which neither channel moves an item.
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("watchdog: no handshake for %0d cycles", QUIET_LIMIT);
      $display("status: fail");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Phase one: light sender gaps, heavy receiver stalls. Keep the directed
    // ticks inside the first pulse so the train starts from a known phase.
    test_first_items();
    test_command_extremes();
    test_bad_commands();
    test_pulse_train();
    test_random_traffic(100);

    // Phase two: swap the idle rates.
    sender_idle_pct   = 74;
    receiver_idle_pct = 8;
    test_random_traffic(100);

    // Phase three: full rate on both sides.
    sender_idle_pct   = 0;
    receiver_idle_pct = 0;
    test_random_traffic(100);

    // Drain: drop valid, wait for the last results, then let the pipeline run on
    // idle so that it can show anything it should not.
    in_valid_i <= 1'b0;
    while (expected_drive_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);

    $display("covered %0d items: %0d commands taken, %0d refused, %0d pulses started",
             items_sent, commands_taken, commands_refused, pulse_starts);
    $display("mismatches: %0d", mismatches);
    if (mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
